[src/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants and codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  // Default geometry
  localparam int HEAP_GRANULES_DEF = 65536;
  localparam int FREE_SLOTS_DEF    = 64;

  // One page is 64 KiB, i.e. 4096 granules of 16 bytes
  localparam int PAGE_SHIFT    = 12;
  localparam int PAGE_GRANULES = 1 << PAGE_SHIFT;

  // Largest request in bytes
  localparam logic [31:0] MAX_REQUEST = 32'hF000_0000;

  // Width of the granule need of one request (header included)
  localparam int NEED_W = 29;
  localparam int CFG_W  = 5;
  localparam int ADDR_W = 20;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MEMORY  = 2'd1,
    ST_FREE_IGN   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic CFG_MIN_GROW   = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

endpackage

`default_nettype wire

[src/ffsa_ram.sv]
// ----------------------------------------------------------------------------
// ffsa_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/first_fit_segment_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit heap allocator over 16-byte granules with an address-sorted
// free segment table, a per-granule header store and page-wise heap growth.
// ----------------------------------------------------------------------------
// Result path: null, outside-heap, too-large and unknown requests are answered
//   straight from idle; query, and free ignored on its header, after the header
//   read; allocate and free after a walk that reads each table entry scanned
//   and shifts entries on remove/insert.
// Throughput: one request at a time; busy is high while the sequencer is out
//   of idle and drops as the result strobe rises. The table walk sets this.
// Reset (synchronous): free table emptied, heap size zero, both config
//   registers 16. Header store and table contents are not cleared.
// The result strobe out_valid lasts one cycle; the receiver cannot stall.
`default_nettype none

module first_fit_segment_allocator #(
  parameter int HEAP_GRANULES = ffsa_pkg::HEAP_GRANULES_DEF,
  parameter int FREE_SLOTS    = ffsa_pkg::FREE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_request_bytes,
  input  logic [19:0] in_address,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [19:0] out_result_address,
  output logic [19:0] out_usable_bytes,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  import ffsa_pkg::*;

  localparam int GW  = $clog2(HEAP_GRANULES);
  localparam int SW  = GW + 1;
  localparam int EW  = GW + SW;
  localparam int AW  = $clog2(FREE_SLOTS);
  localparam int CW  = $clog2(FREE_SLOTS + 1);
  localparam int CAP = HEAP_GRANULES / PAGE_GRANULES;

  typedef enum logic [4:0] {
    S_IDLE, S_A_RD, S_A_CK, S_A_GROW, S_A_SPLIT, S_A_HDR,
    S_REM_RD, S_REM_WR,
    S_I_HDR, S_I_RD, S_I_CK, S_I_DEC, S_I_BHDR, S_I_SH_RD, S_I_SH_WR, S_I_END,
    S_F_CK, S_Q_CK
  } state_t;

  // registers
  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  piu_r, piu_nxt;
  logic [CFG_W-1:0]  min_grow_r, heap_lim_r;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [GW-1:0]     g_r, g_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic [GW-1:0]     ig_r, ig_nxt;
  logic [SW-1:0]     il_r, il_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     sh_r, sh_nxt;
  logic [GW-1:0]     prev_start_r, prev_start_nxt;
  logic [SW-1:0]     prev_len_r, prev_len_nxt;
  logic [GW-1:0]     cur_start_r, cur_start_nxt;
  logic [SW-1:0]     cur_len_r, cur_len_nxt;
  logic              cur_ok_r, cur_ok_nxt;
  logic              fwd_r, fwd_nxt;
  logic              ret_alloc_r, ret_alloc_nxt;
  logic              rem_ins_r, rem_ins_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [ADDR_W-1:0] res_usable_r, res_usable_nxt;
  logic              out_valid_r, out_valid_nxt;

  // memory ports
  logic          seg_we;
  logic [AW-1:0] seg_waddr, seg_raddr;
  logic [EW-1:0] seg_wdata, seg_rdata;
  logic          hdr_we;
  logic [GW-1:0] hdr_waddr, hdr_raddr;
  logic [SW:0]   hdr_wdata, hdr_rdata;

  // helper values
  logic [31:0]   n_bytes, need_full, gran_m1, heap_top;
  logic          too_big, in_heap;
  logic [31:0]   pneed, pages, lim, addr32, use32, qry32;
  logic          grow_fail;
  logic [GW-1:0] rd_start;
  logic [SW-1:0] rd_len, hdr_size, il_m, bwd_len;
  logic          hdr_free, fwd, bwd;
  logic [CW-1:0] idx_m1, idx_p1, sh_m1;

  ffsa_ram #(.DEPTH(FREE_SLOTS), .WIDTH(EW)) u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  ffsa_ram #(.DEPTH(HEAP_GRANULES), .WIDTH(SW + 1)) u_hdr (
    .clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
    .raddr(hdr_raddr), .rdata(hdr_rdata)
  );

  // request decode
  assign n_bytes   = (in_request_bytes == 32'd0) ? 32'd1 : in_request_bytes;
  assign too_big   = n_bytes > MAX_REQUEST;
  assign need_full = ((n_bytes + 32'd15) >> 4) + 32'd1;
  assign gran_m1   = {16'd0, in_address[19:4]} - 32'd1;
  assign heap_top  = 32'(piu_r) << PAGE_SHIFT;
  assign in_heap   = (in_address != '0) && (in_address[19:4] != '0) && (gran_m1 < heap_top);
  assign hdr_raddr = GW'(gran_m1);

  // heap growth
  assign pneed = (32'(need_r) + 32'(PAGE_GRANULES - 1)) >> PAGE_SHIFT;
  assign pages = (pneed > 32'(min_grow_r)) ? pneed : 32'(min_grow_r);
  assign lim   = (32'(heap_lim_r) < 32'(CAP)) ? 32'(heap_lim_r) : 32'(CAP);
  assign grow_fail = (32'(piu_r) > lim) || (pages > lim - 32'(piu_r));

  // memory read fields
  assign rd_start = seg_rdata[EW-1:SW];
  assign rd_len   = seg_rdata[SW-1:0];
  assign hdr_size = hdr_rdata[SW-1:0];
  assign hdr_free = hdr_rdata[SW];

  // neighbor merge checks
  assign fwd     = cur_ok_r && ((32'(ig_r) + 32'(il_r)) == 32'(cur_start_r));
  assign bwd     = (idx_r != '0) && ((32'(prev_start_r) + 32'(prev_len_r)) == 32'(ig_r));
  assign il_m    = fwd ? SW'(il_r + cur_len_r) : il_r;
  assign bwd_len = SW'(prev_len_r + il_m);

  assign idx_m1 = idx_r - 1'b1;
  assign idx_p1 = idx_r + 1'b1;
  assign sh_m1  = sh_r - 1'b1;

  // result values
  assign addr32 = (32'(g_r) + 32'd1) << 4;
  assign use32  = (32'(size_r) - 32'd1) << 4;
  assign qry32  = (32'(hdr_size) - 32'd1) << 4;

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    piu_nxt        = piu_r;
    need_nxt       = need_r;
    g_nxt          = g_r;
    size_nxt       = size_r;
    ig_nxt         = ig_r;
    il_nxt         = il_r;
    idx_nxt        = idx_r;
    sh_nxt         = sh_r;
    prev_start_nxt = prev_start_r;
    prev_len_nxt   = prev_len_r;
    cur_start_nxt  = cur_start_r;
    cur_len_nxt    = cur_len_r;
    cur_ok_nxt     = cur_ok_r;
    fwd_nxt        = fwd_r;
    ret_alloc_nxt  = ret_alloc_r;
    rem_ins_nxt    = rem_ins_r;
    status_nxt     = status_r;
    res_addr_nxt   = res_addr_r;
    res_usable_nxt = res_usable_r;
    out_valid_nxt  = 1'b0;
    seg_we         = 1'b0;
    seg_waddr      = idx_r[AW-1:0];
    seg_wdata      = {ig_r, il_r};
    seg_raddr      = idx_r[AW-1:0];
    hdr_we         = 1'b0;
    hdr_waddr      = ig_r;
    hdr_wdata      = {1'b1, il_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt     = ST_OK;
          res_addr_nxt   = '0;
          res_usable_nxt = '0;
          unique case (in_kind)
            KIND_ALLOC: begin
              if (too_big) begin
                status_nxt    = ST_NO_MEMORY;
                out_valid_nxt = 1'b1;
              end else begin
                need_nxt      = NEED_W'(need_full);
                idx_nxt       = '0;
                ret_alloc_nxt = 1'b1;
                rem_ins_nxt   = 1'b0;
                state_nxt     = S_A_RD;
              end
            end
            KIND_FREE: begin
              if (in_address == '0) begin
                out_valid_nxt = 1'b1;
              end else if (!in_heap) begin
                status_nxt    = ST_FREE_IGN;
                out_valid_nxt = 1'b1;
              end else begin
                ig_nxt        = GW'(gran_m1);
                ret_alloc_nxt = 1'b0;
                state_nxt     = S_F_CK;
              end
            end
            KIND_QUERY: begin
              if (!in_heap) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_Q_CK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // first-fit scan of the free table
      S_A_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_A_GROW;
        end else begin
          state_nxt = S_A_CK;
        end
      end
      S_A_CK: begin
        if (32'(rd_len) >= 32'(need_r)) begin
          g_nxt       = rd_start;
          size_nxt    = rd_len;
          rem_ins_nxt = 1'b0;
          state_nxt   = S_REM_RD;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_A_RD;
        end
      end
      S_A_GROW: begin
        if (grow_fail) begin
          status_nxt    = ST_NO_MEMORY;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          g_nxt     = GW'(32'(piu_r) << PAGE_SHIFT);
          size_nxt  = SW'(pages << PAGE_SHIFT);
          piu_nxt   = CFG_W'(32'(piu_r) + pages);
          state_nxt = S_A_SPLIT;
        end
      end
      // split off a tail of two or more granules
      S_A_SPLIT: begin
        if (32'(size_r) >= 32'(need_r) + 32'd2) begin
          ig_nxt    = GW'(32'(g_r) + 32'(need_r));
          il_nxt    = SW'(32'(size_r) - 32'(need_r));
          size_nxt  = SW'(need_r);
          state_nxt = S_I_HDR;
        end else begin
          state_nxt = S_A_HDR;
        end
      end
      S_A_HDR: begin
        hdr_we         = 1'b1;
        hdr_waddr      = g_r;
        hdr_wdata      = {1'b0, size_r};
        res_addr_nxt   = addr32[ADDR_W-1:0];
        res_usable_nxt = use32[ADDR_W-1:0];
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      // remove entry idx: shift the tail down one slot
      S_REM_RD: begin
        seg_raddr = idx_p1[AW-1:0];
        if (idx_p1 >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = rem_ins_r ? S_I_END : S_A_SPLIT;
        end else begin
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        seg_we    = 1'b1;
        seg_waddr = idx_r[AW-1:0];
        seg_wdata = seg_rdata;
        idx_nxt   = idx_p1;
        state_nxt = S_REM_RD;
      end

      // sorted insert with coalescing
      S_I_HDR: begin
        hdr_we     = 1'b1;
        idx_nxt    = '0;
        cur_ok_nxt = 1'b0;
        state_nxt  = S_I_RD;
      end
      S_I_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_I_DEC;
        end else begin
          state_nxt = S_I_CK;
        end
      end
      S_I_CK: begin
        if (rd_start < ig_r) begin
          prev_start_nxt = rd_start;
          prev_len_nxt   = rd_len;
          idx_nxt        = idx_p1;
          state_nxt      = S_I_RD;
        end else begin
          cur_start_nxt = rd_start;
          cur_len_nxt   = rd_len;
          cur_ok_nxt    = 1'b1;
          state_nxt     = S_I_DEC;
        end
      end
      S_I_DEC: begin
        il_nxt = il_m;
        if (bwd) begin
          seg_we       = 1'b1;
          seg_waddr    = idx_m1[AW-1:0];
          seg_wdata    = {prev_start_r, bwd_len};
          hdr_we       = 1'b1;
          hdr_wdata    = {1'b1, il_m};
          prev_len_nxt = bwd_len;
          fwd_nxt      = fwd;
          state_nxt    = S_I_BHDR;
        end else if (fwd) begin
          seg_we    = 1'b1;
          seg_wdata = {ig_r, il_m};
          hdr_we    = 1'b1;
          hdr_wdata = {1'b1, il_m};
          state_nxt = S_I_END;
        end else if (32'(cnt_r) >= 32'(FREE_SLOTS)) begin
          status_nxt = ST_TABLE_FULL;
          state_nxt  = S_I_END;
        end else begin
          sh_nxt    = cnt_r;
          state_nxt = S_I_SH_RD;
        end
      end
      S_I_BHDR: begin
        hdr_we    = 1'b1;
        hdr_waddr = prev_start_r;
        hdr_wdata = {1'b1, prev_len_r};
        if (fwd_r) begin
          rem_ins_nxt = 1'b1;
          state_nxt   = S_REM_RD;
        end else begin
          state_nxt = S_I_END;
        end
      end
      // open a slot at idx by shifting the tail up
      S_I_SH_RD: begin
        seg_raddr = sh_m1[AW-1:0];
        if (sh_r == idx_r) begin
          seg_we    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_I_END;
        end else begin
          state_nxt = S_I_SH_WR;
        end
      end
      S_I_SH_WR: begin
        seg_we    = 1'b1;
        seg_waddr = sh_r[AW-1:0];
        seg_wdata = seg_rdata;
        sh_nxt    = sh_m1;
        state_nxt = S_I_SH_RD;
      end
      S_I_END: begin
        if (ret_alloc_r) begin
          state_nxt = S_A_HDR;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // free: header read was issued in idle
      S_F_CK: begin
        if (hdr_free || (hdr_size == '0)) begin
          status_nxt    = ST_FREE_IGN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          il_nxt    = hdr_size;
          state_nxt = S_I_HDR;
        end
      end
      // query usable size
      S_Q_CK: begin
        if (hdr_size != '0) begin
          res_usable_nxt = qry32[ADDR_W-1:0];
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      piu_r       <= '0;
      min_grow_r  <= CFG_W'(16);
      heap_lim_r  <= CFG_W'(16);
      out_valid_r <= 1'b0;
      ret_alloc_r <= 1'b0;
      rem_ins_r   <= 1'b0;
      cur_ok_r    <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      piu_r       <= piu_nxt;
      out_valid_r <= out_valid_nxt;
      ret_alloc_r <= ret_alloc_nxt;
      rem_ins_r   <= rem_ins_nxt;
      cur_ok_r    <= cur_ok_nxt;
      fwd_r       <= fwd_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_GROW:   min_grow_r <= cfg_data;
          CFG_HEAP_LIMIT: heap_lim_r <= cfg_data;
        endcase
      end
    end
    need_r       <= need_nxt;
    g_r          <= g_nxt;
    size_r       <= size_nxt;
    ig_r         <= ig_nxt;
    il_r         <= il_nxt;
    idx_r        <= idx_nxt;
    sh_r         <= sh_nxt;
    prev_start_r <= prev_start_nxt;
    prev_len_r   <= prev_len_nxt;
    cur_start_r  <= cur_start_nxt;
    cur_len_r    <= cur_len_nxt;
    status_r     <= status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_usable_r <= res_usable_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_address = res_addr_r;
  assign out_usable_bytes   = res_usable_r;

endmodule

`default_nettype wire

[bench/first_fit_segment_allocator_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_tb
// Drives allocate, free, query and unknown-kind requests into the allocator and
// compares every result with an in-bench first-fit heap predictor that keeps its
// own segment table, header store and page count.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator_tb;
  import ffsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_G  = 65536;
  localparam int SLOTS   = 64;

  typedef struct packed {
    status_t     status;
    logic [19:0] addr;
    logic [19:0] usable;
  } heap_result_t;

  // --------------------------------------------------------------------------
  // Heap predictor and expectation store
  // --------------------------------------------------------------------------
  class heap_scoreboard;
    int unsigned seg_start[SLOTS];
    int unsigned seg_len[SLOTS];
    int unsigned seg_cnt;
    int unsigned hdr[int unsigned];   // only written entries exist
    int unsigned pages;
    int unsigned min_grow, limit;
    heap_result_t pending[$];
    int errors;
    int unsigned live[$];             // allocated payload addresses

    function void clear();
      seg_cnt = 0; hdr.delete(); pages = 0; min_grow = 16; limit = 16;
      pending.delete(); live.delete();
    endfunction

    function void set_reg(logic idx, logic [4:0] v);
      if (idx == CFG_MIN_GROW) min_grow = v; else limit = v;
    endfunction

    function int unsigned hsize(int unsigned g);
      if (g < HEAP_G && hdr.exists(g)) return hdr[g] & 32'h7FFF_FFFF;
      return 0;
    endfunction

    function void set_hdr(int unsigned g, bit fr, int unsigned sz);
      if (g < HEAP_G) hdr[g] = {fr, sz[30:0]};
    endfunction

    function void drop_seg(int unsigned i);
      for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
        seg_start[k] = seg_start[k+1]; seg_len[k] = seg_len[k+1];
      end
      if (seg_cnt > 0) seg_cnt--;
    endfunction

    // sorted insert with merging; 0 when the piece is leaked
    function bit put_free(int unsigned g, int unsigned len);
      int unsigned i;
      bit fwd, bwd;
      i = 0;
      set_hdr(g, 1, len);
      while (i < seg_cnt && seg_start[i] < g) i++;
      fwd = i < seg_cnt && g + len == seg_start[i];
      bwd = i > 0 && seg_start[i-1] + seg_len[i-1] == g;
      if (fwd) begin
        len += seg_len[i]; set_hdr(g, 1, len);
      end
      if (bwd) begin
        seg_len[i-1] += len; set_hdr(seg_start[i-1], 1, seg_len[i-1]);
        if (fwd) drop_seg(i);
        return 1;
      end
      if (fwd) begin
        seg_start[i] = g; seg_len[i] = len; return 1;
      end
      if (seg_cnt >= SLOTS) return 0;
      for (int unsigned k = seg_cnt; k > i; k--) begin
        seg_start[k] = seg_start[k-1]; seg_len[k] = seg_len[k-1];
      end
      seg_start[i] = g; seg_len[i] = len; seg_cnt++;
      return 1;
    endfunction

    function heap_result_t alloc(logic [31:0] bytes);
      heap_result_t r;
      int unsigned n, need, g, sz, lim, want, pg;
      bit found;
      r = '0; found = 0; g = 0; sz = 0;
      n = (bytes == 0) ? 1 : bytes;
      if (n > MAX_REQUEST) begin
        r.status = ST_NO_MEMORY; return r;
      end
      need = ((n + 15) >> 4) + 1;
      for (int unsigned i = 0; i < seg_cnt && !found; i++)
        if (seg_len[i] >= need) begin
          g = seg_start[i]; sz = seg_len[i]; drop_seg(i); found = 1;
        end
      if (!found) begin
        lim = (limit < HEAP_G / 4096) ? limit : HEAP_G / 4096;
        want = min_grow * 4096;
        if (want < need) want = need;
        pg = (want + 4095) / 4096;
        if (pages > lim || pg > lim - pages) begin
          r.status = ST_NO_MEMORY; return r;
        end
        g = pages * 4096; sz = pg * 4096; pages += pg;
      end
      r.status = ST_OK;
      if (sz >= need + 2) begin
        if (!put_free(g + need, sz - need)) r.status = ST_TABLE_FULL;
        sz = need;
      end
      set_hdr(g, 0, sz);
      r.addr = 20'((g + 1) << 4);
      r.usable = 20'((sz - 1) << 4);
      live.push_back((g + 1) << 4);
      return r;
    endfunction

    // note one accepted request and queue its expected result
    function void note_request(kind_t k, logic [31:0] bytes, logic [19:0] a);
      heap_result_t r;
      int unsigned gran, h;
      bit ins;
      r = '0;
      gran = a >> 4; h = gran - 1;
      ins = a != 0 && gran != 0 && h < pages * 4096;
      case (k)
        KIND_ALLOC: r = alloc(bytes);
        KIND_FREE: begin
          if (a != 0) begin
            if (!ins || hdr[h][31] || hsize(h) == 0) r.status = ST_FREE_IGN;
            else if (!put_free(h, hsize(h))) r.status = ST_TABLE_FULL;
          end
        end
        KIND_QUERY: if (ins && hsize(h) != 0) r.usable = 20'((hsize(h) - 1) << 4);
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task report_err(string s);
      $display("%0t mismatch: %s", $realtime, s);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [19:0] a, logic [19:0] u);
      heap_result_t e;
      if (pending.size() == 0) begin
        report_err("result with no request outstanding"); return;
      end
      e = pending.pop_front();
      if (st !== e.status) report_err($sformatf("status %0d, want %0d", st, e.status));
      if (a !== e.addr) report_err($sformatf("address %h, want %h", a, e.addr));
      if (u !== e.usable) report_err($sformatf("usable %h, want %h", u, e.usable));
    endtask
  endclass

  logic        clk = 0, rst_n = 0, start = 0, cfg_we = 0, cfg_index = 0;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_request_bytes = '0;
  logic [19:0] in_address = '0;
  logic [4:0]  cfg_data = '0;
  logic        busy, out_valid;
  logic [1:0]  out_status;
  logic [19:0] out_result_address, out_usable_bytes;

  heap_scoreboard sb = new();

  first_fit_segment_allocator dut (.*);

  always begin
    #2 clk = 1; #2 clk = 0;
  end

  // result monitor
  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_status, out_result_address, out_usable_bytes);

  // issue one request and hold it until accepted; start stays high for the
  // next request, idle phases drop it
  task automatic send_request(kind_t k, logic [31:0] b, logic [19:0] a);
    in_kind <= k; in_request_bytes <= b; in_address <= a; start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(k, b, a);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  // live block, an address below the first granule, or one above the heap top
  function automatic logic [19:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (sb.live.size() != 0 && r < 8)
      return 20'(sb.live[$urandom_range(0, sb.live.size() - 1)]);
    if (r == 8) return 20'($urandom_range(0, 15));
    if (sb.pages < 16) return 20'($urandom_range(sb.pages * 65536 + 16, 20'hFFFFF));
    return 20'(0);
  endfunction

  // mostly small requests, sometimes large, huge or zero
  function automatic logic [31:0] pick_bytes();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return $urandom_range(4096, 300000);
      2: return 0;
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  task automatic random_phase(int count);
    int burst;
    int gap;
    kind_t k;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          start <= 0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 20);
      end
      burst--;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = KIND_ALLOC;
        4, 5, 6, 7: k = KIND_FREE;
        8: k = KIND_QUERY;
        default: k = kind_t'(2'd3);
      endcase
      send_request(k, pick_bytes(), pick_addr());
      if (i == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    sb.clear();
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes and special cases
    send_request(KIND_FREE, 0, 20'h00000);
    send_request(KIND_QUERY, 0, 20'h00000);
    send_request(KIND_FREE, 0, 20'hFFFFF);
    send_request(KIND_QUERY, 0, 20'h12340);
    send_request(KIND_ALLOC, 32'hFFFF_FFFF, 0);
    send_request(KIND_ALLOC, 32'hF000_0001, 0);
    send_request(KIND_ALLOC, 0, 0);
    send_request(KIND_ALLOC, 1, 0);
    send_request(KIND_ALLOC, 16, 0);
    send_request(KIND_ALLOC, 17, 0);
    send_request(KIND_QUERY, 0, 20'h00010);
    send_request(KIND_FREE, 0, 20'h00010);
    send_request(KIND_FREE, 0, 20'h00010);
    send_request(KIND_QUERY, 0, 20'h00010);
    send_request(kind_t'(2'd3), 32'hFFFF_FFFF, 20'hFFFFF);
    send_request(KIND_ALLOC, 32'h000F_FFE0, 0);
    send_request(KIND_ALLOC, 32'hF000_0000, 0);
    wait_drained();
    // table full: many small holes
    for (int i = 0; i < 140; i++) send_request(KIND_ALLOC, 16, 0);
    for (int i = 0; i < 140; i += 2) send_request(KIND_FREE, 0, 20'(sb.live[5 + i]));
    wait_drained();
    // random phases over several register settings
    write_reg(CFG_MIN_GROW, 5'd1); write_reg(CFG_HEAP_LIMIT, 5'd31);
    random_phase(400);
    rst_n <= 1;
    write_reg(CFG_MIN_GROW, 5'd0); write_reg(CFG_HEAP_LIMIT, 5'd1);
    random_phase(300);
    write_reg(CFG_MIN_GROW, 5'd31); write_reg(CFG_HEAP_LIMIT, 5'd16);
    random_phase(300);
    write_reg(CFG_MIN_GROW, 5'd3); write_reg(CFG_HEAP_LIMIT, 5'd0);
    random_phase(300);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("first_fit_segment_allocator_tb: clean");
    else
      $display("first_fit_segment_allocator_tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("first_fit_segment_allocator_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
